>>> hw/rtl/ezb_pkg.sv
// Shared constants, types and arithmetic helpers for the Euler ZYX basis vector unit.
`timescale 1ns / 1ps

package ezb_pkg;

   localparam int ANGLE_BITS    = 16;
   localparam int VEC_FRAC_BITS = 14;
   localparam int ANGLE_W       = 16;
   localparam int OUT_W         = 16;
   localparam int CORDIC_ITERS  = 30;
   localparam int IDX_W         = $clog2(CORDIC_ITERS);
   localparam int VAL_W         = 32;
   localparam int SUM_W         = VAL_W + 1;
   localparam int OUT_SHIFT     = 30 - VEC_FRAC_BITS;
   localparam logic signed [VAL_W-1:0] CORDIC_GAIN = 32'sd652032874;

   typedef struct packed {
      logic signed [VAL_W-1:0] x;
      logic signed [VAL_W-1:0] y;
      logic signed [VAL_W-1:0] z;
      logic [1:0]              quad;
   } cordic_type;

   // Arctangent of 2^-i as a fraction of a 32-bit turn.
   function automatic logic signed [VAL_W-1:0] atan_turn(input logic [IDX_W-1:0] i);
      logic signed [VAL_W-1:0] r;
      case (i)
         5'd0:  r = 32'sd536870912;
         5'd1:  r = 32'sd316933406;
         5'd2:  r = 32'sd167458907;
         5'd3:  r = 32'sd85004756;
         5'd4:  r = 32'sd42667331;
         5'd5:  r = 32'sd21354465;
         5'd6:  r = 32'sd10679838;
         5'd7:  r = 32'sd5340245;
         5'd8:  r = 32'sd2670163;
         5'd9:  r = 32'sd1335087;
         5'd10: r = 32'sd667544;
         5'd11: r = 32'sd333772;
         5'd12: r = 32'sd166886;
         5'd13: r = 32'sd83443;
         5'd14: r = 32'sd41722;
         5'd15: r = 32'sd20861;
         5'd16: r = 32'sd10430;
         5'd17: r = 32'sd5215;
         5'd18: r = 32'sd2608;
         5'd19: r = 32'sd1304;
         5'd20: r = 32'sd652;
         5'd21: r = 32'sd326;
         5'd22: r = 32'sd163;
         5'd23: r = 32'sd81;
         5'd24: r = 32'sd41;
         5'd25: r = 32'sd20;
         5'd26: r = 32'sd10;
         5'd27: r = 32'sd5;
         5'd28: r = 32'sd3;
         5'd29: r = 32'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Q2.30 product, rounded half up.
   function automatic logic signed [VAL_W-1:0] mul30(input logic signed [VAL_W-1:0] a,
                                                     input logic signed [VAL_W-1:0] b);
      logic signed [2*VAL_W-1:0] p;
      p = a * b + (64'sd1 <<< 29);
      return p[VAL_W+29:30];
   endfunction

   // Round a Q2.30 value to the output format and saturate to +-1.0.
   function automatic logic [OUT_W-1:0] to_out(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      logic signed [SUM_W-1:0] lim;
      lim = SUM_W'(1) <<< VEC_FRAC_BITS;
      if (OUT_SHIFT > 0) begin
         r = (v + (SUM_W'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
      end else begin
         r = v;
      end
      if (r > lim) begin
         r = lim;
      end
      if (r < -lim) begin
         r = -lim;
      end
      return r[OUT_W-1:0];
   endfunction

endpackage

>>> hw/rtl/euler_zyx_basis_vectors_unit.sv
// Top level: three CORDIC chains, matrix product stages and the result register.
`timescale 1ns / 1ps

// Takes one request per cycle unless a held result stalls it, and returns the right, up and
// forward vectors of R = Rz*Ry*Rx through the CORDIC cell chains (one cell per iteration,
// one chain per angle), quadrant mapping, the two levels of Q2.30 products and the sums,
// rounding and saturation that load the result register. When a result is held the whole
// pipeline holds with it.
module euler_zyx_basis_vectors_unit
   import ezb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ANGLE_W-1:0]      req_angle_x,
   input  logic [ANGLE_W-1:0]      req_angle_y,
   input  logic [ANGLE_W-1:0]      req_angle_z,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_right_x,
   output logic signed [OUT_W-1:0] rsp_right_y,
   output logic signed [OUT_W-1:0] rsp_right_z,
   output logic signed [OUT_W-1:0] rsp_up_x,
   output logic signed [OUT_W-1:0] rsp_up_y,
   output logic signed [OUT_W-1:0] rsp_up_z,
   output logic signed [OUT_W-1:0] rsp_forward_x,
   output logic signed [OUT_W-1:0] rsp_forward_y,
   output logic signed [OUT_W-1:0] rsp_forward_z
);

   localparam int NSTAGE = CORDIC_ITERS + 4;

   logic en;
   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] vld_in;

   cordic_type chain [3][CORDIC_ITERS+1];
   logic [ANGLE_W-1:0] ang [3];

   assign en        = ~vld_ff[NSTAGE-1] | rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[NSTAGE-1];
   assign vld_in    = {vld_ff[NSTAGE-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   assign ang[0] = req_angle_x;
   assign ang[1] = req_angle_y;
   assign ang[2] = req_angle_z;

   genvar a, i;
   generate
      for (a = 0; a < 3; a++) begin : g_axis
         logic [31:0] turn;
         assign turn = {ang[a][ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
         assign chain[a][0].x    = CORDIC_GAIN;
         assign chain[a][0].y    = '0;
         assign chain[a][0].z    = VAL_W'(turn[29:0]);
         assign chain[a][0].quad = turn[31:30];
         for (i = 0; i < CORDIC_ITERS; i++) begin : g_cell
            ezb_cordic_cell u_cell (
               .clock       (clock),
               .en          (en),
               .stage_idx   (IDX_W'(i)),
               .cell_in     (chain[a][i]),
               .cell_out_ff (chain[a][i+1])
            );
         end
      end
   endgenerate

   // Quadrant mapping into cosine and sine.
   logic signed [VAL_W-1:0] cos_in [3];
   logic signed [VAL_W-1:0] sin_in [3];
   logic signed [VAL_W-1:0] cos_ff [3];
   logic signed [VAL_W-1:0] sin_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         case (chain[k][CORDIC_ITERS].quad)
            2'd0: begin
               cos_in[k] = chain[k][CORDIC_ITERS].x;
               sin_in[k] = chain[k][CORDIC_ITERS].y;
            end
            2'd1: begin
               cos_in[k] = -chain[k][CORDIC_ITERS].y;
               sin_in[k] = chain[k][CORDIC_ITERS].x;
            end
            2'd2: begin
               cos_in[k] = -chain[k][CORDIC_ITERS].x;
               sin_in[k] = -chain[k][CORDIC_ITERS].y;
            end
            default: begin
               cos_in[k] = chain[k][CORDIC_ITERS].y;
               sin_in[k] = -chain[k][CORDIC_ITERS].x;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   // First product level.
   logic signed [VAL_W-1:0] sysx_ff, sycx_ff, czcy_ff, szcy_ff, cysx_ff, cycx_ff;
   logic signed [VAL_W-1:0] czcx_ff, szcx_ff, czsx_ff, szsx_ff, cz1_ff, sz1_ff, sy1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sysx_ff <= mul30(sin_ff[1], sin_ff[0]);
         sycx_ff <= mul30(sin_ff[1], cos_ff[0]);
         czcy_ff <= mul30(cos_ff[2], cos_ff[1]);
         szcy_ff <= mul30(sin_ff[2], cos_ff[1]);
         cysx_ff <= mul30(cos_ff[1], sin_ff[0]);
         cycx_ff <= mul30(cos_ff[1], cos_ff[0]);
         czcx_ff <= mul30(cos_ff[2], cos_ff[0]);
         szcx_ff <= mul30(sin_ff[2], cos_ff[0]);
         czsx_ff <= mul30(cos_ff[2], sin_ff[0]);
         szsx_ff <= mul30(sin_ff[2], sin_ff[0]);
         cz1_ff  <= cos_ff[2];
         sz1_ff  <= sin_ff[2];
         sy1_ff  <= sin_ff[1];
      end
   end

   // Second product level; the other terms ride along.
   logic signed [VAL_W-1:0] czsysx_ff, szsysx_ff, czsycx_ff, szsycx_ff;
   logic signed [VAL_W-1:0] czcy2_ff, szcy2_ff, cysx2_ff, cycx2_ff;
   logic signed [VAL_W-1:0] czcx2_ff, szcx2_ff, czsx2_ff, szsx2_ff, sy2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         czsysx_ff <= mul30(cz1_ff, sysx_ff);
         szsysx_ff <= mul30(sz1_ff, sysx_ff);
         czsycx_ff <= mul30(cz1_ff, sycx_ff);
         szsycx_ff <= mul30(sz1_ff, sycx_ff);
         czcy2_ff  <= czcy_ff;
         szcy2_ff  <= szcy_ff;
         cysx2_ff  <= cysx_ff;
         cycx2_ff  <= cycx_ff;
         czcx2_ff  <= czcx_ff;
         szcx2_ff  <= szcx_ff;
         czsx2_ff  <= czsx_ff;
         szsx2_ff  <= szsx_ff;
         sy2_ff    <= sy1_ff;
      end
   end

   // Sums, negation of the forward column, rounding and saturation.
   logic signed [SUM_W-1:0] e0, e1, e2, e3, e4, e5, e6, e7, e8;

   always_comb begin
      e0 = SUM_W'(czcy2_ff);
      e1 = SUM_W'(szcy2_ff);
      e2 = -SUM_W'(sy2_ff);
      e3 = SUM_W'(czsysx_ff) - SUM_W'(szcx2_ff);
      e4 = SUM_W'(szsysx_ff) + SUM_W'(czcx2_ff);
      e5 = SUM_W'(cysx2_ff);
      e6 = -(SUM_W'(czsycx_ff) + SUM_W'(szsx2_ff));
      e7 = -(SUM_W'(szsycx_ff) - SUM_W'(czsx2_ff));
      e8 = -SUM_W'(cycx2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_right_x   <= to_out(e0);
         rsp_right_y   <= to_out(e1);
         rsp_right_z   <= to_out(e2);
         rsp_up_x      <= to_out(e3);
         rsp_up_y      <= to_out(e4);
         rsp_up_z      <= to_out(e5);
         rsp_forward_x <= to_out(e6);
         rsp_forward_y <= to_out(e7);
         rsp_forward_z <= to_out(e8);
      end
   end

endmodule

>>> hw/rtl/ezb_cordic_cell.sv
// One rotation step of the pipelined CORDIC chain.
`timescale 1ns / 1ps

module ezb_cordic_cell
   import ezb_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [IDX_W-1:0] stage_idx,
   input  cordic_type       cell_in,
   output cordic_type       cell_out_ff
);

   cordic_type cell_out_in;
   logic signed [VAL_W-1:0] dx;
   logic signed [VAL_W-1:0] dy;
   logic signed [VAL_W-1:0] ang;

   always_comb begin
      dx  = cell_in.y >>> stage_idx;
      dy  = cell_in.x >>> stage_idx;
      ang = atan_turn(stage_idx);
      cell_out_in.quad = cell_in.quad;
      if (cell_in.z >= 0) begin
         cell_out_in.x = cell_in.x - dx;
         cell_out_in.y = cell_in.y + dy;
         cell_out_in.z = cell_in.z - ang;
      end else begin
         cell_out_in.x = cell_in.x + dx;
         cell_out_in.y = cell_in.y - dy;
         cell_out_in.z = cell_in.z + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_out_ff <= cell_out_in;
      end
   end

endmodule

>>> hw/rtl/ezb_checker.sv
// Port-level checks for the Euler ZYX basis vector unit, with its bind.
`timescale 1ns / 1ps

module ezb_checker
   import ezb_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [OUT_W-1:0] rsp_right_x,
   input logic signed [OUT_W-1:0] rsp_up_y,
   input logic signed [OUT_W-1:0] rsp_forward_z
);

   localparam logic signed [OUT_W-1:0] LIM = OUT_W'(1) <<< VEC_FRAC_BITS;

   // A held result does not drop.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // The request side is open whenever no result waits.
   a_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   a_rx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_right_x <= LIM) && (rsp_right_x >= -LIM))
      else $error("right_x out of range");

   a_uy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_up_y <= LIM) && (rsp_up_y >= -LIM))
      else $error("up_y out of range");

   a_fz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_forward_z))
      else $error("stalled result changed");

endmodule

bind euler_zyx_basis_vectors_unit ezb_checker u_ezb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_right_x   (rsp_right_x),
   .rsp_up_y      (rsp_up_y),
   .rsp_forward_z (rsp_forward_z)
);
